// File: rtl/mpo_pkg.sv
// shared constants, types and sine table builder for the multiwave period oscillator
`timescale 1ns / 1ps
package mpo_pkg;

    // field widths
    localparam int FREQ_W     = 24;
    localparam int RATE_W     = 18;
    localparam int WAVE_W     = 3;
    localparam int SAMPLE_W   = 16;
    localparam int CNT_W      = 24;
    localparam int PER_W      = CNT_W + 1;
    localparam int DVD_W      = RATE_W + 8;
    localparam int STEP_W     = $clog2(DVD_W + 1);
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = RATE_W;

    // phase and sine table geometry
    localparam int PHASE_BITS = 12;
    localparam int SINE_DEPTH = 1024;
    localparam int SINE_AW    = $clog2(SINE_DEPTH + 1);
    localparam int MAG_W      = 15;

    localparam logic [FREQ_W-1:0] MIN_FREQ_CODE = FREQ_W'(3);
    localparam logic [PER_W-1:0]  PERIOD_CAP    = PER_W'(1) << CNT_W;
    localparam longint unsigned   HALF_PI_Q30   = 64'd1686629713;

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(44100);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RATE        = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT = 1'b1;

    // wave codes
    localparam logic [WAVE_W-1:0] WAVE_SINE     = 3'd0;
    localparam logic [WAVE_W-1:0] WAVE_SQUARE   = 3'd1;
    localparam logic [WAVE_W-1:0] WAVE_TRIANGLE = 3'd2;
    localparam logic [WAVE_W-1:0] WAVE_SAW      = 3'd3;
    localparam logic [WAVE_W-1:0] WAVE_REV_SAW  = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PERIOD,
        S_CHECK,
        S_MOD,
        S_PH_START,
        S_PHASE,
        S_ROM,
        S_WAVE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef logic [SINE_DEPTH:0][MAG_W-1:0] t_sine_tab;

    function automatic logic [MAG_W-1:0] sine_entry(input int unsigned k);
        longint unsigned t;
        longint unsigned t2;
        longint unsigned term;
        longint unsigned sum;
        longint unsigned prod;
        longint unsigned v;
        t    = (longint'(k) * HALF_PI_Q30) / SINE_DEPTH;
        t2   = (t * t) >> 30;
        term = t;
        sum  = t;
        for (int n = 1; n <= 6; n++) begin
            prod = (term * t2) >> 30;
            case (n)
                1:       term = prod / 64'd6;
                2:       term = prod / 64'd20;
                3:       term = prod / 64'd42;
                4:       term = prod / 64'd72;
                5:       term = prod / 64'd110;
                default: term = prod / 64'd156;
            endcase
            if (n % 2 == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum * 64'd32768 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return MAG_W'(v);
    endfunction

    function automatic t_sine_tab build_sine_tab();
        t_sine_tab tab;
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            tab[k] = sine_entry(k);
        end
        return tab;
    endfunction

endpackage

// File: rtl/mpo_req_if.sv
// request channel carrying one frequency code
`timescale 1ns / 1ps
interface mpo_req_if;
    logic                      valid;
    logic                      ready;
    logic [mpo_pkg::FREQ_W-1:0] frequency_code;

    modport source (output valid, output frequency_code, input ready);
    modport sink   (input valid, input frequency_code, output ready);
endinterface

// File: rtl/mpo_res_if.sv
// result channel carrying one waveform sample
`timescale 1ns / 1ps
interface mpo_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [mpo_pkg::SAMPLE_W-1:0] sample_value;
    logic                               silent;

    modport source (output valid, output sample_value, output silent, input ready);
    modport sink   (input valid, input sample_value, input silent, output ready);
endinterface

// File: rtl/mpo_divider.sv
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mpo_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mpo_pkg::t_div_ctrl            i_ctrl,
    input  logic [mpo_pkg::DVD_W-1:0]     i_dividend,
    input  logic [mpo_pkg::PER_W-1:0]     i_rem,
    input  logic [mpo_pkg::PER_W-1:0]     i_divisor,
    output mpo_pkg::t_div_stat            o_stat,
    output logic [mpo_pkg::DVD_W-1:0]     o_quot,
    output logic [mpo_pkg::PER_W-1:0]     o_rem
);

    logic                         r_busy;
    logic                         r_done;
    logic [mpo_pkg::STEP_W-1:0]   r_cnt;
    logic [mpo_pkg::DVD_W-1:0]    r_dvd;
    logic [mpo_pkg::PER_W-1:0]    r_rem;
    logic [mpo_pkg::PER_W-1:0]    r_div;
    logic [mpo_pkg::DVD_W-1:0]    r_quot;

    logic [mpo_pkg::PER_W:0]      w_shift;
    logic                         w_qbit;
    logic [mpo_pkg::PER_W-1:0]    n_rem;

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
        w_shift = {r_rem, r_dvd[mpo_pkg::DVD_W-1]};
        w_qbit  = (w_shift >= {1'b0, r_div});
        if (w_qbit) begin
            n_rem = mpo_pkg::PER_W'(w_shift - {1'b0, r_div});
        end else begin
            n_rem = mpo_pkg::PER_W'(w_shift);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == mpo_pkg::STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_cnt  <= i_ctrl.steps;
            r_dvd  <= i_dividend;
            r_rem  <= i_rem;
            r_div  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - mpo_pkg::STEP_W'(1);
            r_dvd  <= {r_dvd[mpo_pkg::DVD_W-2:0], 1'b0};
            r_rem  <= n_rem;
            r_quot <= {r_quot[mpo_pkg::DVD_W-2:0], w_qbit};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;
    assign o_rem       = r_rem;

endmodule

// File: rtl/mpo_sine_rom.sv
// quarter-wave sine magnitude rom with registered read
`timescale 1ns / 1ps
module mpo_sine_rom (
    input  logic                          i_clk,
    input  logic [mpo_pkg::SINE_AW-1:0]   i_addr,
    output logic [mpo_pkg::MAG_W-1:0]     o_data
);

    localparam mpo_pkg::t_sine_tab SINE_TAB = mpo_pkg::build_sine_tab();

    logic [mpo_pkg::MAG_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        r_data <= SINE_TAB[i_addr];
    end

    assign o_data = r_data;

endmodule

// File: rtl/multiwave_period_oscillator_unit.sv
// top level: period and phase sequencer with waveform shaping
`timescale 1ns / 1ps
// flow: a code below 3 goes straight to done as silence; otherwise the divider forms the period,
//   a zero period ends silent after the check, and a stale counter gets a modulo pass
// the bit-serial divider then forms the phase, followed by the rom read and shaping states;
//   a stalled output holds the result in the done state
// throughput: one request at a time, the next taken the cycle after the result is loaded
// reset: synchronous active low, clears sequencer, output valid and counter, rate 44100, sine
module multiwave_period_oscillator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [mpo_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [mpo_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    mpo_req_if.sink                            i_req,
    mpo_res_if.source                          o_res
);

    localparam int QBITS = mpo_pkg::PHASE_BITS - 2;
    localparam int PROD_W = QBITS + mpo_pkg::SINE_AW;
    localparam int SH_W = mpo_pkg::PHASE_BITS + 17;

    // configuration registers
    logic [mpo_pkg::RATE_W-1:0]   r_rate;
    logic [mpo_pkg::WAVE_W-1:0]   r_wave;

    // sequencer and datapath state
    mpo_pkg::t_state              r_state;
    mpo_pkg::t_state              n_state;
    logic [mpo_pkg::CNT_W-1:0]    r_counter;
    logic [mpo_pkg::PER_W-1:0]    r_period;
    logic [mpo_pkg::CNT_W-1:0]    r_cm;
    logic [mpo_pkg::PHASE_BITS-1:0] r_phase;
    logic signed [mpo_pkg::SAMPLE_W-1:0] r_value;
    logic                         r_silent;

    // output register
    logic                         r_out_valid;
    logic signed [mpo_pkg::SAMPLE_W-1:0] r_out_value;
    logic                         r_out_silent;

    // divider hookup
    mpo_pkg::t_div_ctrl           w_div_ctrl;
    mpo_pkg::t_div_stat           w_div_stat;
    logic [mpo_pkg::DVD_W-1:0]    w_div_dividend;
    logic [mpo_pkg::PER_W-1:0]    w_div_rem_in;
    logic [mpo_pkg::PER_W-1:0]    w_div_divisor;
    logic [mpo_pkg::DVD_W-1:0]    w_div_quot;
    logic [mpo_pkg::PER_W-1:0]    w_div_rem;

    // misc combinational
    logic                         w_req_take;
    logic                         w_code_low;
    logic                         w_load;
    logic                         w_cnt_below;
    logic [mpo_pkg::PER_W-1:0]    w_period_cap;
    logic [mpo_pkg::PER_W-1:0]    w_cm_inc;
    logic [mpo_pkg::CNT_W-1:0]    n_counter;

    // wave shaping
    logic [1:0]                   w_quad;
    logic [QBITS-1:0]             w_frac;
    logic [PROD_W-1:0]            w_prod;
    logic [mpo_pkg::SINE_AW-1:0]  w_idx;
    logic [mpo_pkg::SINE_AW-1:0]  w_rom_addr;
    logic [mpo_pkg::MAG_W-1:0]    w_rom_data;
    logic [mpo_pkg::PHASE_BITS:0] w_two_ph;
    logic [mpo_pkg::PHASE_BITS:0] w_tri_d;
    logic [SH_W-1:0]              w_tri_sh;
    logic [SH_W-1:0]              w_saw_sh;
    logic [16:0]                  w_tri_u;
    logic [15:0]                  w_saw_u;
    logic [15:0]                  w_rev;
    logic signed [mpo_pkg::SAMPLE_W-1:0] w_wave_value;

    // configuration port, to be written only while idle; the block itself does not enforce this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= mpo_pkg::RATE_RESET;
            r_wave <= mpo_pkg::WAVE_SINE;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mpo_pkg::CFG_RATE: begin
                    r_rate <= i_cfg_data;
                end
                mpo_pkg::CFG_WAVE_SELECT: begin
                    r_wave <= i_cfg_data[mpo_pkg::WAVE_W-1:0];
                end
            endcase
        end
    end

    assign i_req.ready = (r_state == mpo_pkg::S_IDLE);
    assign w_req_take  = i_req.valid && i_req.ready;
    assign w_code_low  = (i_req.frequency_code < mpo_pkg::MIN_FREQ_CODE);

    // result may move into the output register once the slot is free or draining
    assign w_load = (r_state == mpo_pkg::S_DONE) && (!r_out_valid || o_res.ready);

    assign w_cnt_below = ({1'b0, r_counter} < r_period);

    // period saturates at 2^24 so the counter always fits
    assign w_period_cap = (w_div_quot > mpo_pkg::DVD_W'(mpo_pkg::PERIOD_CAP))
                        ? mpo_pkg::PERIOD_CAP : w_div_quot[mpo_pkg::PER_W-1:0];

    // next counter from the reduced counter: (cm + 1) mod period
    assign w_cm_inc  = {1'b0, r_cm} + mpo_pkg::PER_W'(1);
    assign n_counter = (w_cm_inc == r_period) ? '0 : w_cm_inc[mpo_pkg::CNT_W-1:0];

    // next-state logic
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mpo_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = w_code_low ? mpo_pkg::S_DONE : mpo_pkg::S_PERIOD;
                end
            end
            mpo_pkg::S_PERIOD: begin
                if (w_div_stat.done) begin
                    n_state = mpo_pkg::S_CHECK;
                end
            end
            mpo_pkg::S_CHECK: begin
                if (r_period == '0) begin
                    n_state = mpo_pkg::S_DONE;
                end else if (w_cnt_below) begin
                    n_state = mpo_pkg::S_PH_START;
                end else begin
                    n_state = mpo_pkg::S_MOD;
                end
            end
            mpo_pkg::S_MOD: begin
                if (w_div_stat.done) begin
                    n_state = mpo_pkg::S_PH_START;
                end
            end
            mpo_pkg::S_PH_START: begin
                n_state = mpo_pkg::S_PHASE;
            end
            mpo_pkg::S_PHASE: begin
                if (w_div_stat.done) begin
                    n_state = mpo_pkg::S_ROM;
                end
            end
            mpo_pkg::S_ROM: begin
                n_state = mpo_pkg::S_WAVE;
            end
            mpo_pkg::S_WAVE: begin
                n_state = mpo_pkg::S_DONE;
            end
            mpo_pkg::S_DONE: begin
                if (w_load) begin
                    n_state = mpo_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mpo_pkg::S_IDLE;
            end
        endcase
    end

    // divider launch controls
    always_comb begin
        w_div_ctrl.start = 1'b0;
        w_div_ctrl.steps = mpo_pkg::STEP_W'(mpo_pkg::DVD_W);
        w_div_dividend   = {r_rate, 8'b0};
        w_div_rem_in     = '0;
        w_div_divisor    = r_period;
        unique case (r_state)
            mpo_pkg::S_IDLE: begin
                // period = rate * 256 / code
                w_div_ctrl.start = w_req_take && !w_code_low;
                w_div_divisor    = {1'b0, i_req.frequency_code};
            end
            mpo_pkg::S_CHECK: begin
                // stale counter: reduce modulo the period
                w_div_ctrl.start = (r_period != '0) && !w_cnt_below;
                w_div_ctrl.steps = mpo_pkg::STEP_W'(mpo_pkg::CNT_W);
                w_div_dividend   = {r_counter, {(mpo_pkg::DVD_W - mpo_pkg::CNT_W){1'b0}}};
            end
            mpo_pkg::S_PH_START: begin
                // phase = cm * 2^PHASE_BITS / period, remainder seeded with cm
                w_div_ctrl.start = 1'b1;
                w_div_ctrl.steps = mpo_pkg::STEP_W'(mpo_pkg::PHASE_BITS);
                w_div_dividend   = '0;
                w_div_rem_in     = {1'b0, r_cm};
            end
            default: begin
                w_div_ctrl.start = 1'b0;
            end
        endcase
    end

    mpo_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (w_div_ctrl),
        .i_dividend (w_div_dividend),
        .i_rem      (w_div_rem_in),
        .i_divisor  (w_div_divisor),
        .o_stat     (w_div_stat),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // sine lookup: quadrant from the top phase bits, mirror in odd quadrants
    assign w_quad     = r_phase[mpo_pkg::PHASE_BITS-1 -: 2];
    assign w_frac     = r_phase[QBITS-1:0];
    assign w_prod     = PROD_W'(w_frac) * PROD_W'(mpo_pkg::SINE_DEPTH);
    assign w_idx      = mpo_pkg::SINE_AW'(w_prod >> QBITS);
    assign w_rom_addr = w_quad[0] ? (mpo_pkg::SINE_AW'(mpo_pkg::SINE_DEPTH) - w_idx) : w_idx;

    mpo_sine_rom u_sine_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_rom_data)
    );

    // triangle and sawtooth scaling to 16 bits
    assign w_two_ph = {r_phase, 1'b0};
    assign w_tri_d  = w_two_ph[mpo_pkg::PHASE_BITS]
                    ? (w_two_ph - (mpo_pkg::PHASE_BITS+1)'(1 << mpo_pkg::PHASE_BITS))
                    : ((mpo_pkg::PHASE_BITS+1)'(1 << mpo_pkg::PHASE_BITS) - w_two_ph);
    assign w_tri_sh = {w_tri_d, 16'b0} >> mpo_pkg::PHASE_BITS;
    assign w_saw_sh = {1'b0, r_phase, 16'b0} >> mpo_pkg::PHASE_BITS;
    assign w_tri_u  = w_tri_sh[16:0];
    assign w_saw_u  = w_saw_sh[15:0];
    // 32768 - saw wraps to the signed result; only a zero phase reaches +1
    assign w_rev    = 16'h8000 - w_saw_u;

    always_comb begin
        case (r_wave)
            mpo_pkg::WAVE_SINE: begin
                w_wave_value = w_quad[1] ? -$signed({1'b0, w_rom_data})
                                         :  $signed({1'b0, w_rom_data});
            end
            mpo_pkg::WAVE_SQUARE: begin
                // raw counter against half the period
                w_wave_value = ({1'b0, r_counter} < (r_period >> 1)) ? 16'sh7FFF : 16'sh8000;
            end
            mpo_pkg::WAVE_TRIANGLE: begin
                w_wave_value = w_tri_u[16] ? 16'sh7FFF : $signed(w_tri_u[15:0] ^ 16'h8000);
            end
            mpo_pkg::WAVE_SAW: begin
                w_wave_value = $signed(w_saw_u ^ 16'h8000);
            end
            mpo_pkg::WAVE_REV_SAW: begin
                w_wave_value = (w_saw_u == '0) ? 16'sh7FFF : $signed(w_rev);
            end
            default: begin
                w_wave_value = '0;
            end
        endcase
    end

    // sequencer state, output valid and sample counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mpo_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_counter   <= '0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
                if (!r_silent) begin
                    r_counter <= n_counter;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            mpo_pkg::S_IDLE: begin
                if (w_req_take) begin
                    r_silent <= w_code_low;
                    r_value  <= '0;
                end
            end
            mpo_pkg::S_PERIOD: begin
                if (w_div_stat.done) begin
                    r_period <= w_period_cap;
                end
            end
            mpo_pkg::S_CHECK: begin
                if (r_period == '0) begin
                    r_silent <= 1'b1;
                    r_value  <= '0;
                end else if (w_cnt_below) begin
                    r_cm <= r_counter;
                end
            end
            mpo_pkg::S_MOD: begin
                if (w_div_stat.done) begin
                    r_cm <= w_div_rem[mpo_pkg::CNT_W-1:0];
                end
            end
            mpo_pkg::S_PHASE: begin
                if (w_div_stat.done) begin
                    r_phase <= w_div_quot[mpo_pkg::PHASE_BITS-1:0];
                end
            end
            mpo_pkg::S_WAVE: begin
                r_value <= w_wave_value;
            end
            default: begin
                r_value <= r_value;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_value  <= r_value;
            r_out_silent <= r_silent;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.sample_value = r_out_value;
    assign o_res.silent       = r_out_silent;

    // divider never runs while a request can be taken
    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mpo_pkg::S_IDLE) |-> !w_div_stat.busy)
        else $error("divider busy in idle");

    // phase division always starts from a reduced counter
    a_cm_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mpo_pkg::S_PH_START) |-> ({1'b0, r_cm} < r_period))
        else $error("counter not reduced before phase division");

    // a tone result leaves the counter inside the period
    a_counter_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && !r_silent) |=> ({1'b0, r_counter} < r_period))
        else $error("counter left outside period");

    // silence always carries a zero sample
    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_silent) |-> (r_out_value == '0))
        else $error("silent result with nonzero sample");

endmodule

// File: verif/tb_multiwave_period_oscillator_unit.sv
// self-checking testbench for the multiwave period oscillator unit
`timescale 1ns / 1ps
module tb_multiwave_period_oscillator_unit;
    import mpo_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int REPORT_MAX    = 10;

    // wave codes with no shape behind them
    localparam logic [WAVE_W-1:0] WAVE_UNUSED_LO = 3'd5;
    localparam logic [WAVE_W-1:0] WAVE_UNUSED_HI = 3'd7;

    localparam logic [RATE_W-1:0] RATE_LOW       = RATE_W'(8000);
    localparam logic [RATE_W-1:0] RATE_HIGH      = RATE_W'(192000);
    localparam logic [RATE_W-1:0] RATE_FIELD_MAX = '1;
    localparam logic [FREQ_W-1:0] FREQ_FIELD_MAX = '1;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       silent;
    } t_sample;

    typedef enum logic { ROW_CFG, ROW_REQ } t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [FREQ_W-1:0]     code;
        bit                    typed;
        t_sample               want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mpo_req_if req_if ();
    mpo_res_if res_if ();

    multiwave_period_oscillator_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // oscillator copy: registers, sample counter, quarter-wave table
    logic [RATE_W-1:0] osc_rate;
    logic [WAVE_W-1:0] osc_wave;
    logic [CNT_W-1:0]  osc_counter;
    logic [MAG_W-1:0]  quarter_tab [0:SINE_DEPTH];

    t_sample sample_q [$];
    int      mismatches  = 0;
    int      idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // expected sample for one request, advances the counter copy
    function automatic t_sample next_sample(input logic [FREQ_W-1:0] code);
        t_sample         s;
        longint unsigned period;
        longint unsigned phase;
        longint unsigned tri_span;
        longint unsigned slot;
        longint unsigned quad;
        longint unsigned full;
        longint          value;
        s.value  = '0;
        s.silent = 1'b1;
        full     = 64'd1 << PHASE_BITS;
        period   = 0;
        value    = 0;
        if (code >= MIN_FREQ_CODE) begin
            period = osc_rate;
            period = (period << 8) / code;
            if (period > PERIOD_CAP) begin
                period = PERIOD_CAP;
            end
        end
        if (period != 0) begin
            // phase from the counter wrapped into the current period
            phase = ((osc_counter % period) << PHASE_BITS) / period;
            case (osc_wave)
                WAVE_SINE: begin
                    quad = (phase >> (PHASE_BITS - 2)) & 64'd3;
                    slot = ((phase & ((64'd1 << (PHASE_BITS - 2)) - 1)) * SINE_DEPTH)
                           >> (PHASE_BITS - 2);
                    if (slot > SINE_DEPTH) begin
                        slot = SINE_DEPTH;
                    end
                    value = quad[0] ? quarter_tab[SINE_DEPTH - slot] : quarter_tab[slot];
                    if (quad[1]) begin
                        value = -value;
                    end
                end
                // square compares the raw counter, not the wrapped one
                WAVE_SQUARE: value = (osc_counter < period / 2) ? 32767 : -32768;
                WAVE_TRIANGLE: begin
                    tri_span = (2 * phase >= full) ? 2 * phase - full : full - 2 * phase;
                    value    = $signed((64'd65536 * tri_span) >> PHASE_BITS) - 32768;
                    if (value > 32767) begin
                        value = 32767;
                    end
                end
                WAVE_SAW: value = $signed((64'd65536 * phase) >> PHASE_BITS) - 32768;
                WAVE_REV_SAW: begin
                    value = 32768 - $signed((64'd65536 * phase) >> PHASE_BITS);
                    if (value > 32767) begin
                        value = 32767;
                    end
                end
                default: value = 0;
            endcase
            osc_counter = CNT_W'((osc_counter + 64'd1) % period);
            s.value     = value[SAMPLE_W-1:0];
            s.silent    = 1'b0;
        end
        return s;
    endfunction

    function automatic t_row cfg_row(input logic [CFG_IDX_W-1:0] index,
                                     input logic [CFG_DATA_W-1:0] data);
        t_row r;
        r.kind  = ROW_CFG;
        r.index = index;
        r.data  = data;
        r.code  = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_row tone_row(input logic [FREQ_W-1:0] code);
        t_row r;
        r       = cfg_row(CFG_RATE, '0);
        r.kind  = ROW_REQ;
        r.code  = code;
        return r;
    endfunction

    function automatic t_row typed_row(input logic [FREQ_W-1:0] code,
                                       input logic signed [SAMPLE_W-1:0] value,
                                       input logic silent);
        t_row r;
        r             = tone_row(code);
        r.typed       = 1'b1;
        r.want.value  = value;
        r.want.silent = silent;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input longint want, input longint got);
        if (mismatches < REPORT_MAX) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
        mismatches++;
    endtask

    // lower the request and wait until every sample is back
    task automatic wait_for_samples();
        if (req_if.valid) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
        while (sample_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_for_samples();
        @(negedge i_clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge i_clk);
        if (index == CFG_RATE) begin
            osc_rate = data;
        end else begin
            osc_wave = data[WAVE_W-1:0];
        end
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_sample_request(input logic [FREQ_W-1:0] code, input bit typed,
                                       input t_sample want);
        t_sample predicted;
        @(negedge i_clk);
        req_if.valid          <= 1'b1;
        req_if.frequency_code <= code;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        predicted = next_sample(code);
        sample_q.push_back(typed ? want : predicted);
    endtask

    task automatic sender_pause(input int cycles);
        @(negedge i_clk);
        req_if.valid          <= 1'b0;
        req_if.frequency_code <= FREQ_W'($urandom);
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // tone for a run: mostly short periods so the counter wraps often
    function automatic logic [FREQ_W-1:0] pick_tone();
        longint unsigned code;
        longint unsigned span;
        case ($urandom_range(0, 9))
            0: code = $urandom % (64'd1 << FREQ_W);
            1: code = $urandom_range(0, 3);
            2: code = $urandom_range(3, 400);
            default: begin
                span = $urandom_range(1, 48);
                code = osc_rate;
                code = (code << 8) / span;
                if (code < MIN_FREQ_CODE) begin
                    code = $urandom_range(3, 4000);
                end
            end
        endcase
        if (code > FREQ_FIELD_MAX) begin
            code = FREQ_FIELD_MAX;
        end
        return code[FREQ_W-1:0];
    endfunction

    // sample checker
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (sample_q.size() == 0) begin
                flag_mismatch("sample with no request", 0, res_if.sample_value);
            end else begin
                want = sample_q.pop_front();
                if (res_if.sample_value !== want.value) begin
                    flag_mismatch("sample_value", want.value, res_if.sample_value);
                end
                if (res_if.silent !== want.silent) begin
                    flag_mismatch("silent", want.silent, res_if.silent);
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // receiver: ready stretches, short stalls, and long calm spells
    initial begin : receiver
        int   hold;
        logic level;
        res_if.ready = 1'b0;
        hold         = 0;
        level        = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold == 0) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        level = 1'b1;
                        hold  = $urandom_range(1, 40);
                    end
                    5, 6, 7: begin
                        level = 1'b0;
                        hold  = $urandom_range(1, 12);
                    end
                    default: begin
                        level = 1'b1;
                        hold  = $urandom_range(100, 300);
                    end
                endcase
            end
            hold--;
            res_if.ready <= level;
        end
    end

    initial begin : stimulus
        t_row            rows [$];
        t_sample         blank;
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned acc;
        logic [FREQ_W-1:0]     tone;
        logic [FREQ_W-1:0]     code;
        logic [CFG_DATA_W-1:0] wave_data;
        int              burst_left;
        int              seq_len;
        int              phase_no;
        int              random_sent;
        int              pick;

        i_rst_n               = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_index             = CFG_RATE;
        cfg_data              = '0;
        req_if.valid          = 1'b0;
        req_if.frequency_code = '0;
        blank                 = '0;

        // quarter-wave table by the truncating taylor series in q2.30
        for (int k = 0; k <= SINE_DEPTH; k++) begin
            ang    = (longint'(k) * HALF_PI_Q30) / SINE_DEPTH;
            ang_sq = (ang * ang) >> 30;
            term   = ang;
            acc    = ang;
            for (int n = 1; n <= 6; n++) begin
                term = ((term * ang_sq) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) begin
                    acc = (acc >= term) ? acc - term : 64'd0;
                end else begin
                    acc = acc + term;
                end
            end
            acc            = (acc * 64'd32768 + (64'd1 << 29)) >> 30;
            quarter_tab[k] = (acc > 64'd32767) ? 15'h7FFF : acc[MAG_W-1:0];
        end
        osc_rate    = RATE_RESET;
        osc_wave    = WAVE_SINE;
        osc_counter = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, starting from reset settings (44100, sine)
        rows.push_back(typed_row(24'd0, 16'sd0, 1'b1));       // no frequency source
        rows.push_back(typed_row(24'd1, 16'sd0, 1'b1));
        rows.push_back(typed_row(24'd2, 16'sd0, 1'b1));
        rows.push_back(typed_row(24'd3, 16'sd0, 1'b0));       // lowest tone, counter at zero
        rows.push_back(typed_row(FREQ_FIELD_MAX, 16'sd0, 1'b1)); // period rounds to zero
        rows.push_back(tone_row(24'd112640));                 // 440 hz, period 100
        rows.push_back(tone_row(24'd112640));
        rows.push_back(cfg_row(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_SQUARE)));
        rows.push_back(tone_row(24'd112640));
        rows.push_back(cfg_row(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_TRIANGLE)));
        rows.push_back(tone_row(24'd112640));
        rows.push_back(cfg_row(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_SAW)));
        rows.push_back(tone_row(24'd112640));
        rows.push_back(cfg_row(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_REV_SAW)));
        rows.push_back(tone_row(24'd112640));
        rows.push_back(cfg_row(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_UNUSED_LO)));
        rows.push_back(typed_row(24'd112640, 16'sd0, 1'b0));  // unknown wave still counts
        rows.push_back(cfg_row(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_UNUSED_HI)));
        rows.push_back(typed_row(24'd112640, 16'sd0, 1'b0));
        rows.push_back(cfg_row(CFG_RATE, '0));
        rows.push_back(typed_row(24'd3, 16'sd0, 1'b1));       // zero rate gives zero period
        rows.push_back(cfg_row(CFG_RATE, RATE_FIELD_MAX));
        rows.push_back(cfg_row(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_SINE)));
        rows.push_back(tone_row(24'd3));                      // period clipped to 2^24
        rows.push_back(cfg_row(CFG_RATE, RATE_LOW));
        rows.push_back(cfg_row(CFG_WAVE_SELECT, CFG_DATA_W'(WAVE_SQUARE)));
        rows.push_back(tone_row(24'd256));                    // 1 hz, period 8000
        rows.push_back(tone_row(24'd256));
        rows.push_back(tone_row(24'd256));
        rows.push_back(tone_row(24'd1024000));                // period 2 with a stale counter
        rows.push_back(tone_row(24'd1024000));
        rows.push_back(cfg_row(CFG_RATE, RATE_HIGH));
        rows.push_back(tone_row(24'h5A5A5A));
        rows.push_back(tone_row(24'hA5A5A5));

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CFG) begin
                write_register(rows[i].index, rows[i].data);
            end else begin
                send_sample_request(rows[i].code, rows[i].typed, rows[i].want);
            end
        end

        // random part: runs of one tone under one setting, with noise and tone changes
        burst_left  = 0;
        phase_no    = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            if (phase_no == 0 || $urandom_range(0, 2) != 0) begin
                case ($urandom_range(0, 8))
                    0:       write_register(CFG_RATE, RATE_LOW);
                    1:       write_register(CFG_RATE, RATE_HIGH);
                    2:       write_register(CFG_RATE, '0);
                    3:       write_register(CFG_RATE, RATE_FIELD_MAX);
                    4:       write_register(CFG_RATE, RATE_RESET);
                    5:       write_register(CFG_RATE, CFG_DATA_W'($urandom));
                    default: begin
                        write_register(CFG_RATE, CFG_DATA_W'($urandom_range(8000, 192000)));
                    end
                endcase
            end
            if (phase_no == 0 || $urandom_range(0, 2) != 0) begin
                wave_data = $urandom_range(0, 1) ? CFG_DATA_W'($urandom) : '0;
                if ($urandom_range(0, 4) == 0) begin
                    wave_data[WAVE_W-1:0] = WAVE_W'($urandom_range(5, 7));
                end else begin
                    wave_data[WAVE_W-1:0] = WAVE_W'($urandom_range(0, 4));
                end
                write_register(CFG_WAVE_SELECT, wave_data);
            end
            tone    = pick_tone();
            seq_len = $urandom_range(16, 64);
            for (int n = 0; n < seq_len; n++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 20);
                    if ($urandom_range(0, 3) != 0) begin
                        sender_pause($urandom_range(1, 15));
                    end
                end
                burst_left--;
                // hold off mid-run until the block has drained
                if (phase_no % 4 == 0 && n == seq_len / 2) begin
                    wait_for_samples();
                end
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    tone = pick_tone();   // new period, counter may be stale
                end
                if (pick == 1) begin
                    code = FREQ_W'($urandom);
                end else if (pick == 2) begin
                    code = FREQ_W'($urandom_range(0, 3));
                end else begin
                    code = tone;
                end
                send_sample_request(code, 1'b0, blank);
                random_sent++;
            end
            phase_no++;
        end

        wait_for_samples();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && sample_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
